FILE: src/nal_emulation_prevention_strip_core_macros.svh
// Assertion macros used by the port-level checks of the NAL strip core.
// Relies on clk and arst_n being visible where a macro is used.
`ifndef NAL_EMULATION_PREVENTION_STRIP_CORE_MACROS_SVH
`define NAL_EMULATION_PREVENTION_STRIP_CORE_MACROS_SVH

// same-cycle implication
`define NPE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("npe assertion failed");

// next-cycle implication
`define NPE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("npe assertion failed");

`endif

FILE: src/npe_pkg.sv
// Shared types and constants of the NAL emulation prevention strip core.
// No dependencies.
package npe_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_BYTE0 = 3'd1;
	localparam logic [2:0] ST_BYTE1 = 3'd2;
	localparam logic [2:0] ST_BYTE2 = 3'd3;
	localparam logic [2:0] ST_BYTE3 = 3'd4;
	localparam logic [2:0] ST_TRUNC = 3'd5;

	typedef enum logic [5:0] {
		PH_B0      = 6'b000001,
		PH_B1      = 6'b000010,
		PH_B2      = 6'b000100,
		PH_B3      = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_DISCARD = 6'b100000
	} phase_t;

	// Work for the back end: an optional held byte (never last, always ok)
	// followed by an optional second result.
	typedef struct packed {
		logic       v0;
		logic [7:0] b0;
		logic       v1;
		logic [7:0] b1;
		logic       l1;
		logic [2:0] st1;
	} op_t;

endpackage

FILE: src/npe_front.sv
// Front end: accepts raw bytes, checks the start code, strips emulation prevention
// 03 bytes and turns the remaining bytes into work entries. Depends on npe_pkg.
module npe_front import npe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       full,
	output logic       push,
	output op_t        op
);

	phase_t     phase_q, phase_d;
	logic [1:0] zr_q, zr_d;
	logic [7:0] hb_q, hb_d;
	logic       hv_q, hv_d;
	logic [2:0] err;
	logic       accept;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && (op.v0 || op.v1);

	always_comb begin
		phase_d = phase_q;
		zr_d    = zr_q;
		hb_d    = hb_q;
		hv_d    = hv_q;
		op      = '0;
		err     = ST_OK;
		unique case (phase_q)
			PH_B0: begin
				if (s_tdata != 8'd0) err = ST_BYTE0;
				else if (s_tlast) err = ST_TRUNC;
				else phase_d = PH_B1;
			end
			PH_B1: begin
				if (s_tdata != 8'd0) err = ST_BYTE1;
				else if (s_tlast) err = ST_TRUNC;
				else phase_d = PH_B2;
			end
			PH_B2: begin
				if (s_tdata >= 8'd2) err = ST_BYTE2;
				else if (s_tlast) err = ST_TRUNC;
				else if (s_tdata == 8'd1) begin
					phase_d = PH_PAYLOAD;
					zr_d    = 2'd0;
					hv_d    = 1'b0;
				end else phase_d = PH_B3;
			end
			PH_B3: begin
				if (s_tdata != 8'd1) err = ST_BYTE3;
				else if (s_tlast) err = ST_TRUNC;
				else begin
					phase_d = PH_PAYLOAD;
					zr_d    = 2'd0;
					hv_d    = 1'b0;
				end
			end
			PH_PAYLOAD: begin
				if (zr_q == 2'd2 && s_tdata == 8'h03) begin
					// drop the emulation prevention byte
					zr_d = 2'd0;
					if (s_tlast) begin
						op.v1  = 1'b1;
						op.b1  = hv_q ? hb_q : 8'd0;
						op.l1  = 1'b1;
						op.st1 = hv_q ? ST_OK : ST_TRUNC;
						phase_d = PH_B0;
						hb_d    = 8'd0;
						hv_d    = 1'b0;
					end
				end else begin
					op.v0 = hv_q;
					op.b0 = hb_q;
					if (s_tlast) begin
						op.v1   = 1'b1;
						op.b1   = s_tdata;
						op.l1   = 1'b1;
						op.st1  = ST_OK;
						phase_d = PH_B0;
						zr_d    = 2'd0;
						hb_d    = 8'd0;
						hv_d    = 1'b0;
					end else begin
						hb_d = s_tdata;
						hv_d = 1'b1;
						if (s_tdata == 8'd0) zr_d = (zr_q == 2'd2) ? 2'd2 : zr_q + 2'd1;
						else zr_d = 2'd0;
					end
				end
			end
			PH_DISCARD: begin
				if (s_tlast) begin
					phase_d = PH_B0;
					zr_d    = 2'd0;
					hb_d    = 8'd0;
					hv_d    = 1'b0;
				end
			end
			default: begin
				phase_d = PH_B0;
				zr_d    = 2'd0;
				hb_d    = 8'd0;
				hv_d    = 1'b0;
			end
		endcase
		if (err != ST_OK) begin
			op.v1  = 1'b1;
			op.b1  = 8'd0;
			op.l1  = 1'b1;
			op.st1 = err;
			if (err == ST_TRUNC || s_tlast) begin
				phase_d = PH_B0;
				zr_d    = 2'd0;
				hb_d    = 8'd0;
				hv_d    = 1'b0;
			end else phase_d = PH_DISCARD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_B0;
			zr_q    <= 2'd0;
			hb_q    <= 8'd0;
			hv_q    <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			zr_q    <= zr_d;
			hb_q    <= hb_d;
			hv_q    <= hv_d;
		end
	end

endmodule

FILE: src/npe_queue.sv
// Short work queue between front and back end.
// Depends on npe_pkg.
module npe_queue import npe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output op_t  head,
	output logic empty,
	output logic full
);

	op_t            entry_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign head  = entry_q[rd_ptr_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (QAW+1)'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (push && !pop) cnt_q <= cnt_q + (QAW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (QAW+1)'(1);
		end
	end

endmodule

FILE: src/npe_back.sv
// Back end: expands each work entry into one or two result items and
// drives the output register. Depends on npe_pkg.
module npe_back import npe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  op_t        head,
	input  logic       empty,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic [2:0] m_tuser
);

	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;
	logic [2:0] m_tuser_q;
	logic       pos_q;
	logic       load;
	logic       take;
	logic       take0;

	assign load  = !m_tvalid_q || m_tready;
	assign take  = load && !empty;
	assign take0 = head.v0 && !pos_q;
	// keep the entry when its held byte goes out and a second result follows
	assign pop   = take && !(take0 && head.v1);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			pos_q      <= 1'b0;
		end else begin
			if (load) m_tvalid_q <= !empty;
			if (take) pos_q <= take0 && head.v1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (take0) begin
				m_tdata_q <= head.b0;
				m_tlast_q <= 1'b0;
				m_tuser_q <= ST_OK;
			end else begin
				m_tdata_q <= head.b1;
				m_tlast_q <= head.l1;
				m_tuser_q <= head.st1;
			end
		end
	end

endmodule

FILE: src/nal_emulation_prevention_strip_core.sv
// Path: a result item goes through a work queue entry and the output register
// after the byte that causes it is accepted.
// Throughput: one byte per cycle while the queue is not full; the single-port
// back end sends one item per cycle while the output does not stall, so a
// unit end with two items keeps its entry, absorbed by the four-entry queue.
// Reset: arst_n clears the start-code state, the queue and the output valid.
module nal_emulation_prevention_strip_core import npe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic       m_tlast,
	output logic [2:0] m_tuser   // [2:0] status
);

	op_t  push_op;
	op_t  head;
	logic push;
	logic pop;
	logic empty;
	logic full;

	npe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.full     (full),
		.push     (push),
		.op       (push_op)
	);

	npe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	npe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: src/npe_check.sv
// Port-level checks on the NAL strip core, bound to the top level.
// Depends on npe_pkg and the assertion macro header.
`include "nal_emulation_prevention_strip_core_macros.svh"

module npe_check import npe_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [2:0] m_tuser
);

	logic [11:0] m_item;

	assign m_item = {m_tdata, m_tlast, m_tuser};

	// a stalled item holds
	`NPE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_item))
	// error and truncated items close the unit
	`NPE_ASSERT_NOW(a_err_last, m_tvalid && m_tuser != ST_OK, m_tlast)
	// error and truncated items carry no byte
	`NPE_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser != ST_OK, m_tdata == 8'd0)
	// no status beyond truncated
	`NPE_ASSERT_NOW(a_status_range, m_tvalid, m_tuser <= ST_TRUNC)

endmodule

bind nal_emulation_prevention_strip_core npe_check u_check (.*);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for nal_emulation_prevention_strip_core: NAL unit bytes in, stripped
// payload items out, checked in order against a start-code and 03-removal predictor.
// Depends on npe_pkg and the core only.
module tb_top import npe_pkg::*; ;

	localparam int N_DIR      = 28;
	localparam int N_RANDOM   = 1900;
	localparam int MAX_CYCLES = 200000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [2:0] status;
	} nal_out_t;

	// is_err rows end in one error item: byte 0, last 1, the status given
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_err;
		logic [2:0] status;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [2:0] m_tuser;

	// predictor state
	phase_t     sc_phase;
	logic [1:0] zero_run;
	logic [7:0] held_byte;
	logic       held_valid;

	nal_out_t payload_q[$];
	int       bytes_sent;
	int       bad_count;
	int       cycles;
	bit       calm;

	dir_row_t dir_tab [N_DIR] = '{
		'{8'hFF, 1'b0, 1'b1, ST_BYTE0},  // bad first byte, rest discarded
		'{8'h00, 1'b1, 1'b0, ST_OK},
		'{8'h01, 1'b1, 1'b1, ST_BYTE0},  // bad first byte that is also last
		'{8'h00, 1'b1, 1'b1, ST_TRUNC},  // unit ends inside start code
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h80, 1'b1, 1'b1, ST_BYTE1},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h02, 1'b0, 1'b1, ST_BYTE2},
		'{8'hFF, 1'b1, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h7F, 1'b1, 1'b1, ST_BYTE3},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h01, 1'b1, 1'b1, ST_TRUNC},  // complete start code, no payload
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h01, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h03, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h03, 1'b1, 1'b0, ST_OK}   // trailing 03 dropped, held zero goes out last
	};

	nal_emulation_prevention_strip_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	always #10 clk = ~clk;

	function automatic void clear_unit();
		sc_phase   = PH_B0;
		zero_run   = 2'd0;
		held_byte  = 8'h00;
		held_valid = 1'b0;
	endfunction

	// Advance the predictor by one input byte; returns the number of items it yields.
	function automatic int strip_step(input logic [7:0] b, input logic l,
			output nal_out_t r0, output nal_out_t r1);
		int         n;
		logic [2:0] err;
		nal_out_t   res [2];
		n = 0;
		err = ST_OK;
		res[0] = '0;
		res[1] = '0;
		case (sc_phase)
			PH_B1: begin
				if (b != 8'h00) err = ST_BYTE1;
				else if (l) err = ST_TRUNC;
				else sc_phase = PH_B2;
			end
			PH_B2: begin
				if (b >= 8'h02) err = ST_BYTE2;
				else if (l) err = ST_TRUNC;
				else if (b == 8'h01) begin
					sc_phase = PH_PAYLOAD;
					zero_run = 2'd0;
					held_valid = 1'b0;
				end else sc_phase = PH_B3;
			end
			PH_B3: begin
				if (b != 8'h01) err = ST_BYTE3;
				else if (l) err = ST_TRUNC;
				else begin
					sc_phase = PH_PAYLOAD;
					zero_run = 2'd0;
					held_valid = 1'b0;
				end
			end
			PH_PAYLOAD: begin
				if (zero_run == 2'd2 && b == 8'h03) begin
					// drop the emulation prevention byte
					zero_run = 2'd0;
					if (l) begin
						if (held_valid) res[n] = nal_out_t'{held_byte, 1'b1, ST_OK};
						else res[n] = nal_out_t'{8'h00, 1'b1, ST_TRUNC};
						n++;
						clear_unit();
					end
				end else begin
					if (held_valid) begin
						res[n] = nal_out_t'{held_byte, 1'b0, ST_OK};
						n++;
					end
					if (l) begin
						res[n] = nal_out_t'{b, 1'b1, ST_OK};
						n++;
						clear_unit();
					end else begin
						held_byte = b;
						held_valid = 1'b1;
						if (b != 8'h00) zero_run = 2'd0;
						else if (zero_run != 2'd2) zero_run = zero_run + 2'd1;
					end
				end
			end
			PH_DISCARD: begin
				if (l) clear_unit();
			end
			default: begin
				if (b != 8'h00) err = ST_BYTE0;
				else if (l) err = ST_TRUNC;
				else sc_phase = PH_B1;
			end
		endcase
		if (err != ST_OK) begin
			res[n] = nal_out_t'{8'h00, 1'b1, err};
			n++;
			if (err == ST_TRUNC || l) clear_unit();
			else sc_phase = PH_DISCARD;
		end
		r0 = res[0];
		r1 = res[1];
		return n;
	endfunction

	// Offer one byte, wait for its acceptance, then queue what it should yield.
	task automatic send_byte(input logic [7:0] b, input logic l, input logic is_err,
			input logic [2:0] st);
		nal_out_t r0;
		nal_out_t r1;
		int       n;
		while (!calm && $urandom_range(99) < 27) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
		n = strip_step(b, l, r0, r1);
		if (is_err) payload_q.push_back(nal_out_t'{8'h00, 1'b1, st});
		else begin
			if (n > 0) payload_q.push_back(r0);
			if (n > 1) payload_q.push_back(r1);
		end
	endtask

	// Zeros and 03s are common so that prevention sequences show up often.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0, 1, 2, 3: return 8'h00;
			4, 5: return 8'h03;
			6: return 8'($urandom_range(1, 2));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_unit();
		int plen;
		bit four;
		if ($urandom_range(99) < 82) begin
			four = 1'($urandom_range(1));
			plen = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
			send_byte(8'h00, 1'b0, 1'b0, ST_OK);
			send_byte(8'h00, 1'b0, 1'b0, ST_OK);
			if (four) send_byte(8'h00, 1'b0, 1'b0, ST_OK);
			send_byte(8'h01, plen == 0, 1'b0, ST_OK);
			for (int k = 0; k < plen; k++)
				send_byte(pick_byte(), k == plen - 1, 1'b0, ST_OK);
		end else begin
			// broken or short units
			plen = $urandom_range(1, 6);
			for (int k = 0; k < plen; k++)
				send_byte($urandom_range(1) ? 8'h00 : pick_byte(), k == plen - 1, 1'b0, ST_OK);
		end
	endtask

	always @(posedge clk) begin
		nal_out_t got;
		nal_out_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = nal_out_t'{m_tdata, m_tlast, m_tuser};
				if (payload_q.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("unexpected item: data %h last %b status %0d",
							got.data, got.last, got.status);
				end else begin
					want = payload_q.pop_front();
					if (got.data !== want.data || got.last !== want.last ||
							got.status !== want.status) begin
						bad_count++;
						if (bad_count <= 10)
							$display("mismatch: exp %h %b %0d, got %h %b %0d",
								want.data, want.last, want.status,
								got.data, got.last, got.status);
					end
				end
			end
			m_tready <= calm || ($urandom_range(99) >= 27);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == MAX_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		bit paused;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		calm = 1'b0;
		paused = 1'b0;
		bytes_sent = 0;
		bad_count = 0;
		cycles = 0;
		clear_unit();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].is_err, dir_tab[i].status);

		while (bytes_sent < N_DIR + N_RANDOM) begin
			calm = (bytes_sent >= 700 && bytes_sent < 1000);
			if (!paused && bytes_sent >= 1200) begin
				// hold off until the output side has drained
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (payload_q.size() != 0) @(posedge clk);
				paused = 1'b1;
			end
			send_unit();
		end
		s_tvalid <= 1'b0;

		while (payload_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (bad_count == 0 && payload_q.size() == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/npe_pkg.sv
src/npe_front.sv
src/npe_queue.sv
src/npe_back.sv
src/nal_emulation_prevention_strip_core.sv
src/npe_check.sv
test/tb_top.sv
